@@ sv/gww_pkg.sv @@
package gww_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] REG_DELIMITER  = 2'd1;
    localparam logic [1:0] REG_WRAP_LONG  = 2'd2;

    localparam logic [7:0] LINE_WIDTH_RST = 8'd40;
    localparam logic [7:0] DELIMITER_RST  = 8'd32;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        MODE_WORD       = 4'b0001,
        MODE_DELIM      = 4'b0010,
        MODE_SKIP_WORD  = 4'b0100,
        MODE_SKIP_DELIM = 4'b1000
    } t_mode;

    // classified text byte
    typedef struct packed {
        logic is_end;
        logic is_delim;
    } t_item;

    // head of the queue as seen by the back part
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage

@@ sv/gww_front.sv @@
module gww_front
    import gww_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic [7:0] i_delimiter,
    input  logic       i_pop,
    output t_qhead     o_head
);

    t_item              r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_push;
    t_item              w_item;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign w_push  = i_valid && o_ready;

    // end byte wins over a zero delimiter
    assign w_item.is_end   = (i_text_byte == 8'd0);
    assign w_item.is_delim = (i_text_byte == i_delimiter);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/gww_back.sv @@
module gww_back
    import gww_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qhead      i_head,
    output logic        o_pop,
    input  logic [7:0]  i_line_width,
    input  logic        i_wrap_long,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_line_start,
    output logic [7:0]  o_line_length,
    output logic [15:0] o_line_number,
    output logic        o_is_last
);

    localparam int OB = OFFSET_BITS;

    logic [OB-1:0] r_pos, n_pos;
    logic [OB-1:0] r_cls, n_cls;
    logic [OB-1:0] r_lwe, n_lwe;
    logic [OB-1:0] r_cws, n_cws;
    t_mode         r_mode, n_mode;
    logic          r_first, n_first;
    logic [15:0]   r_lines, n_lines;

    logic          r_out_valid;
    logic [15:0]   r_start;
    logic [7:0]    r_len;
    logic [15:0]   r_num;
    logic          r_last;

    logic          w_emit;
    logic [7:0]    w_len;
    logic          w_last;
    logic [7:0]    w_width;
    logic [OB-1:0] w_span_p;
    logic [OB-1:0] w_span_w;
    logic          w_over;

    function automatic logic [OB-1:0] span(input logic [OB-1:0] from, input logic [OB-1:0] to);
        span = (to >= from) ? (to - from) : '0;
    endfunction

    function automatic logic [7:0] sat8(input logic [OB-1:0] v);
        sat8 = (v > OB'(8'hFF)) ? 8'hFF : v[7:0];
    endfunction

    assign o_pop    = i_head.valid && (!r_out_valid || i_ready);
    assign w_width  = (i_line_width == 8'd0) ? 8'd1 : i_line_width;
    assign w_span_p = span(r_cls, r_pos);
    assign w_span_w = span(r_cls, r_lwe);
    assign w_over   = (w_span_p >= OB'(w_width));

    always_comb begin
        n_pos   = r_pos;
        n_cls   = r_cls;
        n_lwe   = r_lwe;
        n_cws   = r_cws;
        n_mode  = r_mode;
        n_first = r_first;
        n_lines = r_lines;
        w_emit  = 1'b0;
        w_len   = w_width;
        w_last  = 1'b0;
        if (i_head.item.is_end) begin
            // close the open line, then back to the start of a text
            w_emit = (r_pos != '0);
            w_last = 1'b1;
            unique case (r_mode)
                MODE_WORD:  w_len = sat8(w_span_p);
                MODE_DELIM: w_len = sat8(w_span_w);
                default:    w_len = w_width;
            endcase
            n_pos   = '0;
            n_cls   = '0;
            n_lwe   = '0;
            n_cws   = '0;
            n_mode  = MODE_WORD;
            n_first = 1'b1;
            n_lines = '0;
        end else begin
            unique case (r_mode)
                MODE_WORD: begin
                    if (i_head.item.is_delim) begin
                        n_lwe  = r_pos;
                        n_mode = MODE_DELIM;
                    end else if (w_over) begin
                        if (r_first) begin
                            if (i_wrap_long) begin
                                w_emit = 1'b1;
                                w_len  = w_width;
                                n_cls  = r_pos;
                                n_cws  = r_pos;
                            end else begin
                                n_mode = MODE_SKIP_WORD;
                            end
                        end else begin
                            w_emit  = 1'b1;
                            w_len   = sat8(w_span_w);
                            n_cls   = r_cws;
                            n_first = 1'b1;
                        end
                    end
                end
                MODE_DELIM: begin
                    if (!i_head.item.is_delim) begin
                        if (w_over) begin
                            w_emit  = 1'b1;
                            w_len   = sat8(w_span_w);
                            n_cls   = r_pos;
                            n_first = 1'b1;
                        end else begin
                            n_first = 1'b0;
                        end
                        n_cws  = r_pos;
                        n_mode = MODE_WORD;
                    end
                end
                MODE_SKIP_WORD: begin
                    if (i_head.item.is_delim) begin
                        n_mode = MODE_SKIP_DELIM;
                    end
                end
                MODE_SKIP_DELIM: begin
                    if (!i_head.item.is_delim) begin
                        w_emit  = 1'b1;
                        w_len   = w_width;
                        n_cls   = r_pos;
                        n_cws   = r_pos;
                        n_first = 1'b1;
                        n_mode  = MODE_WORD;
                    end
                end
                default: begin
                    n_mode = MODE_WORD;
                end
            endcase
            if (r_pos != '1) begin
                n_pos = r_pos + 1'b1;
            end
            if (w_emit && (r_lines != 16'hFFFF)) begin
                n_lines = r_lines + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_cls       <= '0;
            r_lwe       <= '0;
            r_cws       <= '0;
            r_mode      <= MODE_WORD;
            r_first     <= 1'b1;
            r_lines     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos   <= n_pos;
                r_cls   <= n_cls;
                r_lwe   <= n_lwe;
                r_cws   <= n_cws;
                r_mode  <= n_mode;
                r_first <= n_first;
                r_lines <= n_lines;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_start <= 16'(r_cls);
            r_len   <= w_len;
            r_num   <= r_lines;
            r_last  <= w_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_line_start  = r_start;
    assign o_line_length = r_len;
    assign o_line_number = r_num;
    assign o_is_last     = r_last;

endmodule

@@ sv/greedy_word_wrap_lines_unit.sv @@
// channel  direction  handshake          payload
// text     in         i_valid / o_ready  i_text_byte
// lines    out        o_valid / i_ready  o_line_start, o_line_length, o_line_number, o_is_last
// config   in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one text byte per cycle sustained while the output is not stalled; a byte is
// held in a queue slot, then stepped by the back part, and any line result it
// ends is written into the output register
// the per-byte step is one compare-and-add pass in the back part
// synchronous active-low reset clears the queue, the scan state and the
// output register; config registers return to width 40, delimiter 32, no wrap
// a stalled output holds the back part; the two-entry queue keeps taking
// bytes until it fills, then o_ready drops
module greedy_word_wrap_lines_unit
    import gww_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // text bytes
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    // line results
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_line_start,
    output logic [7:0]  o_line_length,
    output logic [15:0] o_line_number,
    output logic        o_is_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_line_width;
    logic [7:0] r_delimiter;
    logic       r_wrap_long;

    logic       w_cfg_wr;
    logic [1:0] w_reg_idx;
    t_qhead     w_head;
    logic       w_pop;

    // register port: always ready, write lands on the access cycle
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_delimiter  <= DELIMITER_RST;
            r_wrap_long  <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_LINE_WIDTH: r_line_width <= pwdata[7:0];
                REG_DELIMITER:  r_delimiter  <= pwdata[7:0];
                REG_WRAP_LONG:  r_wrap_long  <= pwdata[0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_reg_idx)
            REG_LINE_WIDTH: prdata = {24'd0, r_line_width};
            REG_DELIMITER:  prdata = {24'd0, r_delimiter};
            REG_WRAP_LONG:  prdata = {31'd0, r_wrap_long};
            default:        prdata = 32'd0;
        endcase
    end

    // front: take bytes, tag end and delimiter, queue them
    gww_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_delimiter (r_delimiter),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    // back: wrap state machine and output register
    gww_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_line_width  (r_line_width),
        .i_wrap_long   (r_wrap_long),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_line_start  (o_line_start),
        .o_line_length (o_line_length),
        .o_line_number (o_line_number),
        .o_is_last     (o_is_last)
    );

    // a full queue must have something to hand the back part
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> w_head.valid)
        else $error("queue full but head not valid");

    // a new line only appears after the back part stepped a byte
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_pop))
        else $error("line result without a step");

    // a held result blocks the back part
    a_stall_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !w_pop)
        else $error("step taken while result stalled");

endmodule
